// ===== rtl/sdrp_pkg.sv =====
// ----------------------------------------------------------------------------
// sdrp_pkg
// Shared types, codes and helpers of the socket data report parser.
// ----------------------------------------------------------------------------
package sdrp_pkg;

	localparam int SOCKET_BITS = 8;
	localparam int COUNT_BITS  = 12;

	localparam logic [SOCKET_BITS-1:0] SOCKET_MAX = '1;
	localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;

	// operation codes of the command channel
	localparam logic [1:0] OP_CHAR    = 2'd0;
	localparam logic [1:0] OP_START   = 2'd1;
	localparam logic [1:0] OP_TIMEOUT = 2'd2;

	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_SOCKET  = 3'd1,
		PH_SKIP    = 3'd2,
		PH_COUNT   = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_DONE    = 3'd5
	} phase_t;

	typedef struct packed {
		logic       bad;
		logic [3:0] value;
	} nibble_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	// a non-hex character decodes as all ones
	function automatic nibble_t nibble_of(input logic [7:0] c);
		nibble_t n;
		logic [7:0] d;
		n = '{bad: 1'b1, value: 4'hf};
		d = 8'h00;
		if (is_digit(c)) begin
			d = c - CH_0;
			n = '{bad: 1'b0, value: d[3:0]};
		end else if (c >= CH_UA && c <= CH_UF) begin
			d = c - CH_UA + 8'd10;
			n = '{bad: 1'b0, value: d[3:0]};
		end else if (c >= CH_LA && c <= CH_LF) begin
			d = c - CH_LA + 8'd10;
			n = '{bad: 1'b0, value: d[3:0]};
		end
		return n;
	endfunction

endpackage

// ===== rtl/sdrp_if.sv =====
// ----------------------------------------------------------------------------
// sdrp_cmd_if, sdrp_data_if
// Valid/ready channels of the socket data report parser.
// ----------------------------------------------------------------------------
interface sdrp_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] rx_char;

	modport source (output valid, output operation, output rx_char, input ready);
	modport sink (input valid, input operation, input rx_char, output ready);
endinterface

interface sdrp_data_if;
	logic       valid;
	logic       ready;
	logic [7:0] socket_id;
	logic [7:0] payload_byte;
	logic       last;
	logic       bad_hex;

	modport source (output valid, output socket_id, output payload_byte, output last,
		output bad_hex, input ready);
	modport sink (input valid, input socket_id, input payload_byte, input last,
		input bad_hex, output ready);
endinterface

// ===== rtl/socket_data_report_parser.sv =====
// ----------------------------------------------------------------------------
// socket_data_report_parser
// Turns the character stream of a socket data report into payload bytes.
// ----------------------------------------------------------------------------
// cmd carries one word per character or event: operation start arms the
// parser, operation char feeds one received character, operation timeout
// drops back to idle. The report body is "<socket>,<addr>,<port>,<count>,"
// followed by hex pairs; each decoded pair leaves on data together with its
// socket number, the last byte of the report flagged, non-hex pairs flagged
// by bad_hex.
// Throughput is one cmd word per cycle while no byte is stalled on data:
// every character is a single update of the parser state (a decimal
// accumulate or one nibble) done in the cycle it is accepted. A byte shows
// on data the cycle after its second hex character is taken.
// The data register holds a byte until it is taken; while it is stalled,
// cmd.ready follows data.ready, so a word is taken in the same cycle the
// held byte leaves. Reset returns the parser to idle and empties the data
// register; characters are ignored until the next start word.
// ----------------------------------------------------------------------------
module socket_data_report_parser (
	input  logic       clk,
	input  logic       arst_n,
	sdrp_cmd_if.sink   cmd,
	sdrp_data_if.source data
);
	import sdrp_pkg::*;

	phase_t                 phase_q, phase_d;
	logic [SOCKET_BITS-1:0] socket_q, socket_d;
	logic [1:0]             commas_q, commas_d;
	logic [COUNT_BITS-1:0]  bytes_q, bytes_d;
	nibble_t                high_q, high_d;
	logic                   second_q, second_d;

	logic                   out_valid_q;
	logic [7:0]             out_socket_q, out_byte_q;
	logic                   out_last_q, out_bad_q;

	logic                   cmd_acc;
	logic                   emit;
	logic                   digit;
	logic [3:0]             digit_val;
	logic [7:0]             digit_diff;
	nibble_t                nib;
	logic [SOCKET_BITS+3:0] socket_mac;
	logic [COUNT_BITS+3:0]  count_mac;
	logic [SOCKET_BITS-1:0] socket_sat;
	logic [COUNT_BITS-1:0]  count_sat;
	logic [7:0]             byte_val;

	assign cmd.ready = !out_valid_q || data.ready;
	assign cmd_acc   = cmd.valid && cmd.ready;

	assign digit      = is_digit(cmd.rx_char);
	assign digit_diff = cmd.rx_char - CH_0;
	assign digit_val  = digit_diff[3:0];
	assign nib        = nibble_of(cmd.rx_char);

	// acc * 10 + digit, saturating
	assign socket_mac = ({4'd0, socket_q} << 3) + ({4'd0, socket_q} << 1)
		+ {{SOCKET_BITS{1'b0}}, digit_val};
	assign count_mac  = ({4'd0, bytes_q} << 3) + ({4'd0, bytes_q} << 1)
		+ {{COUNT_BITS{1'b0}}, digit_val};
	assign socket_sat = (socket_mac > {4'd0, SOCKET_MAX}) ? SOCKET_MAX
		: socket_mac[SOCKET_BITS-1:0];
	assign count_sat  = (count_mac > {4'd0, COUNT_MAX}) ? COUNT_MAX
		: count_mac[COUNT_BITS-1:0];

	// high nibble of a bad character is all ones, so its low four bits suffice
	assign byte_val = {high_q.value, 4'd0} + (nib.bad ? 8'hff : {4'd0, nib.value});

	always_comb begin
		phase_d  = phase_q;
		socket_d = socket_q;
		commas_d = commas_q;
		bytes_d  = bytes_q;
		high_d   = high_q;
		second_d = second_q;
		emit     = 1'b0;
		case (cmd.operation)
			OP_START: begin
				phase_d  = PH_SOCKET;
				socket_d = '0;
				commas_d = 2'd0;
				bytes_d  = '0;
				high_d   = '{bad: 1'b0, value: 4'd0};
				second_d = 1'b0;
			end
			OP_TIMEOUT: begin
				phase_d = PH_IDLE;
			end
			OP_CHAR: begin
				case (phase_q)
					PH_SOCKET: begin
						if (cmd.rx_char == CH_COMMA) begin
							commas_d = 2'd1;
							phase_d  = PH_SKIP;
						end else if (digit) begin
							socket_d = socket_sat;
						end
					end
					PH_SKIP: begin
						if (cmd.rx_char == CH_COMMA) begin
							commas_d = commas_q + 2'd1;
							if (commas_q == 2'd2)
								phase_d = PH_COUNT;
						end
					end
					PH_COUNT: begin
						if (digit) begin
							bytes_d = count_sat;
						end else begin
							second_d = 1'b0;
							phase_d  = (bytes_q == '0) ? PH_DONE : PH_PAYLOAD;
						end
					end
					PH_PAYLOAD: begin
						if (!second_q) begin
							high_d   = nib;
							second_d = 1'b1;
						end else begin
							second_d = 1'b0;
							bytes_d  = bytes_q - {{(COUNT_BITS-1){1'b0}}, 1'b1};
							emit     = 1'b1;
							if (bytes_q == {{(COUNT_BITS-1){1'b0}}, 1'b1})
								phase_d = PH_DONE;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			socket_q <= '0;
			commas_q <= 2'd0;
			bytes_q  <= '0;
			high_q   <= '{bad: 1'b0, value: 4'd0};
			second_q <= 1'b0;
		end else if (cmd_acc) begin
			phase_q  <= phase_d;
			socket_q <= socket_d;
			commas_q <= commas_d;
			bytes_q  <= bytes_d;
			high_q   <= high_d;
			second_q <= second_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ready) begin
			out_valid_q <= cmd_acc && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc && emit) begin
			out_socket_q <= 8'(socket_q);
			out_byte_q   <= byte_val;
			out_last_q   <= (bytes_q == {{(COUNT_BITS-1){1'b0}}, 1'b1});
			out_bad_q    <= high_q.bad || nib.bad;
		end
	end

	assign data.valid        = out_valid_q;
	assign data.socket_id    = out_socket_q;
	assign data.payload_byte = out_byte_q;
	assign data.last         = out_last_q;
	assign data.bad_hex      = out_bad_q;

`ifndef SYNTHESIS
	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> bytes_q != '0)
		else $error("payload phase with zero bytes left");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && emit && bytes_q == {{(COUNT_BITS-1){1'b0}}, 1'b1}
		|=> phase_q == PH_DONE && data.valid && data.last)
		else $error("last byte did not close the report");

	a_start_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && cmd.operation == OP_START
		|=> phase_q == PH_SOCKET && socket_q == '0 && bytes_q == '0 && !second_q)
		else $error("start word did not rearm the parser");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		data.valid && !data.ready |-> !cmd.ready)
		else $error("cmd taken while a byte is stalled");
`endif

endmodule

// ===== tb/socket_data_report_parser_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// socket_data_report_parser_tb
// Feeds socket data reports, one character word at a time, into the parser
// and compares every payload byte with a cycle-free parser model kept here.
// Directed reports cover ignored words, hex case, saturation, bad hex pairs,
// restarts and timeouts; random reports follow under changing back-pressure.
// ----------------------------------------------------------------------------
module socket_data_report_parser_tb;
	import sdrp_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [7:0] socket_id;
		logic [7:0] payload_byte;
		logic       last;
		logic       bad_hex;
	} report_byte_t;

	logic clk;
	logic arst_n;

	sdrp_cmd_if  cmd_bus ();
	sdrp_data_if data_bus ();

	socket_data_report_parser uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.data   (data_bus)
	);

	// parser model state
	phase_t                 cur_phase;
	logic [SOCKET_BITS-1:0] socket_acc;
	logic [1:0]             commas_seen;
	logic [COUNT_BITS-1:0]  bytes_left;
	logic [7:0]             high_nibble;
	logic                   second_char;

	report_byte_t pending_bytes[$];

	int words_sent;
	int words_taken;
	int error_count;
	int send_idle_pct;
	int recv_stall_pct;
	int cycle_count;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic is_dec(input logic [7:0] ch);
		return ch >= CH_0 && ch <= CH_9;
	endfunction

	// non-hex characters decode as 8'hff, which taints the whole byte
	function automatic logic [7:0] hex_value(input logic [7:0] ch);
		logic [7:0] v;
		v = 8'hff;
		if (is_dec(ch))
			v = ch - CH_0;
		else if (ch >= CH_UA && ch <= CH_UF)
			v = ch - CH_UA + 8'd10;
		else if (ch >= CH_LA && ch <= CH_LF)
			v = ch - CH_LA + 8'd10;
		return v;
	endfunction

	function automatic int dec_accum(input int acc, input logic [7:0] ch, input int limit);
		int v;
		v = acc * 10 + int'(ch - CH_0);
		return v > limit ? limit : v;
	endfunction

	function automatic void parse_word(input logic [1:0] op, input logic [7:0] ch);
		report_byte_t b;
		logic [7:0]   lo;
		case (op)
			OP_START: begin
				cur_phase   = PH_SOCKET;
				socket_acc  = '0;
				commas_seen = '0;
				bytes_left  = '0;
				high_nibble = '0;
				second_char = 1'b0;
			end
			OP_TIMEOUT: cur_phase = PH_IDLE;
			OP_CHAR: begin
				case (cur_phase)
					PH_SOCKET: begin
						if (ch == CH_COMMA) begin
							commas_seen = 2'd1;
							cur_phase   = PH_SKIP;
						end else if (is_dec(ch)) begin
							socket_acc = SOCKET_BITS'(dec_accum(int'(socket_acc), ch,
								int'(SOCKET_MAX)));
						end
					end
					PH_SKIP: begin
						if (ch == CH_COMMA) begin
							commas_seen = commas_seen + 2'd1;
							if (commas_seen == 2'd3)
								cur_phase = PH_COUNT;
						end
					end
					PH_COUNT: begin
						if (is_dec(ch)) begin
							bytes_left = COUNT_BITS'(dec_accum(int'(bytes_left), ch,
								int'(COUNT_MAX)));
						end else begin
							second_char = 1'b0;
							cur_phase   = (bytes_left == '0) ? PH_DONE : PH_PAYLOAD;
						end
					end
					PH_PAYLOAD: begin
						if (!second_char) begin
							high_nibble = hex_value(ch);
							second_char = 1'b1;
						end else begin
							lo             = hex_value(ch);
							second_char    = 1'b0;
							bytes_left     = bytes_left - {{(COUNT_BITS-1){1'b0}}, 1'b1};
							b.socket_id    = socket_acc[7:0];
							b.payload_byte = {high_nibble[3:0], 4'h0} + lo;
							b.last         = (bytes_left == '0);
							b.bad_hex      = (high_nibble == 8'hff) || (lo == 8'hff);
							pending_bytes.push_back(b);
							if (bytes_left == '0)
								cur_phase = PH_DONE;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	endfunction

	// results are checked before the word of the same edge is parsed: a byte
	// never leaves in the cycle its second character is taken
	always @(posedge clk) begin
		if (data_bus.valid && data_bus.ready) begin
			if (pending_bytes.size() == 0) begin
				$error("unexpected byte: socket_id %0d payload_byte %02h",
					data_bus.socket_id, data_bus.payload_byte);
				error_count++;
			end else begin
				report_byte_t exp_b;
				exp_b = pending_bytes.pop_front();
				if (data_bus.socket_id !== exp_b.socket_id) begin
					$error("socket_id: expected %0d, actual %0d", exp_b.socket_id,
						data_bus.socket_id);
					error_count++;
				end
				if (data_bus.payload_byte !== exp_b.payload_byte) begin
					$error("payload_byte: expected %02h, actual %02h", exp_b.payload_byte,
						data_bus.payload_byte);
					error_count++;
				end
				if (data_bus.last !== exp_b.last) begin
					$error("last: expected %0b, actual %0b", exp_b.last, data_bus.last);
					error_count++;
				end
				if (data_bus.bad_hex !== exp_b.bad_hex) begin
					$error("bad_hex: expected %0b, actual %0b", exp_b.bad_hex,
						data_bus.bad_hex);
					error_count++;
				end
			end
		end
		if (cmd_bus.valid && cmd_bus.ready) begin
			parse_word(cmd_bus.operation, cmd_bus.rx_char);
			words_taken++;
		end
	end

	always @(negedge clk)
		data_bus.ready <= ($urandom_range(99) >= recv_stall_pct);

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// called and returns at a falling edge
	task automatic send_word(input logic [1:0] op, input logic [7:0] ch);
		int taken;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_bus.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_bus.valid     <= 1'b1;
		cmd_bus.operation <= op;
		cmd_bus.rx_char   <= ch;
		taken = words_taken;
		do
			@(negedge clk);
		while (words_taken == taken);
		words_sent++;
	endtask

	task automatic send_chars(input string s);
		for (int i = 0; i < s.len(); i++)
			send_word(OP_CHAR, s[i]);
	endtask

	function automatic logic [7:0] rand_hex_char(input int bad_pct);
		string      hex_chars;
		logic [7:0] ch;
		hex_chars = "0123456789ABCDEFabcdef";
		if ($urandom_range(99) < bad_pct) begin
			do
				ch = 8'($urandom_range(255));
			while (hex_value(ch) != 8'hff);
		end else begin
			ch = hex_chars[$urandom_range(hex_chars.len() - 1)];
		end
		return ch;
	endfunction

	function automatic logic [7:0] rand_non_digit();
		logic [7:0] ch;
		do
			ch = 8'($urandom_range(255));
		while (is_dec(ch) || ch == CH_COMMA);
		return ch;
	endfunction

	task automatic test_ignored_words();
		send_word(OP_CHAR, "A");
		send_word(OP_CHAR, 8'hff);
		send_word(OP_UNUSED, 8'h00);
		send_word(OP_TIMEOUT, 8'hff);
	endtask

	task automatic test_basic_report();
		send_word(OP_START, 8'h00);
		send_chars("12,a,8,3,00Ffa9\r");
	endtask

	task automatic test_saturation_and_errors();
		// stray letter in the socket number, then saturation at 255
		send_word(OP_START, 8'h00);
		send_chars("9x99,,,1,A5");
		// zero count: the hex after it is ignored
		send_word(OP_START, 8'h00);
		send_chars("4,,,0,12");
		// count saturates at 4095, then a restart in mid payload
		send_word(OP_START, 8'h00);
		send_chars("7,,,99999,G0");
		send_word(OP_START, 8'h00);
		send_chars("3,,,3,0zG5zz");
		// unused operation inside a pair changes nothing
		send_word(OP_START, 8'h00);
		send_chars("1,,,1,A");
		send_word(OP_UNUSED, 8'hff);
		send_chars("4");
		// timeout in mid report, later characters are dropped
		send_word(OP_START, 8'h00);
		send_chars("2,,,3,11");
		send_word(OP_TIMEOUT, 8'h00);
		send_chars("22");
	endtask

	task automatic send_noise();
		int n;
		n = $urandom_range(1, 4);
		repeat (n)
			send_word(2'($urandom_range(3)), 8'($urandom_range(255)));
	endtask

	task automatic send_random_report();
		string addr_chars;
		int    n_digits;
		int    byte_count;
		int    sent_bytes;
		bit    truncated;
		addr_chars = "0123456789.";
		send_word(OP_START, 8'($urandom_range(255)));
		n_digits = ($urandom_range(9) == 0) ? 4 : $urandom_range(1, 3);
		repeat (n_digits) begin
			if ($urandom_range(11) == 0)
				send_word(OP_CHAR, rand_non_digit());
			send_word(OP_CHAR, 8'(CH_0 + $urandom_range(9)));
		end
		send_word(OP_CHAR, CH_COMMA);
		repeat ($urandom_range(1, 4))
			send_word(OP_CHAR, addr_chars[$urandom_range(addr_chars.len() - 1)]);
		send_word(OP_CHAR, CH_COMMA);
		repeat ($urandom_range(1, 3))
			send_word(OP_CHAR, 8'(CH_0 + $urandom_range(9)));
		send_word(OP_CHAR, CH_COMMA);

		if ($urandom_range(11) == 0)
			byte_count = 0;
		else if ($urandom_range(19) == 0)
			byte_count = $urandom_range(10, 99999);
		else
			byte_count = $urandom_range(1, 6);
		send_chars($sformatf("%0d", byte_count));
		send_word(OP_CHAR, ($urandom_range(6) == 0) ? rand_non_digit() : CH_COMMA);

		// large counts are always cut short
		truncated  = (byte_count > 6) || ($urandom_range(4) == 0);
		sent_bytes = truncated ? $urandom_range(0, 6 < byte_count ? 6 : byte_count) :
			byte_count;
		repeat (sent_bytes) begin
			send_word(OP_CHAR, rand_hex_char(8));
			if ($urandom_range(29) == 0)
				send_word(OP_UNUSED, 8'($urandom_range(255)));
			send_word(OP_CHAR, rand_hex_char(8));
		end
		if (truncated) begin
			if ($urandom_range(1))
				send_word(OP_CHAR, rand_hex_char(8));
			if ($urandom_range(1))
				send_word(OP_TIMEOUT, 8'($urandom_range(255)));
		end else if ($urandom_range(2) == 0) begin
			repeat ($urandom_range(1, 3))
				send_word(OP_CHAR, 8'($urandom_range(255)));
		end
	endtask

	task automatic test_random_reports(input int send_pct, input int stall_pct,
		input int n_words);
		int stop_at;
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
		stop_at        = words_sent + n_words;
		while (words_sent < stop_at) begin
			if ($urandom_range(9) == 0)
				send_noise();
			else
				send_random_report();
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		cmd_bus.valid      = 1'b0;
		cmd_bus.operation  = OP_CHAR;
		cmd_bus.rx_char    = 8'h00;
		data_bus.ready     = 1'b0;
		words_sent         = 0;
		words_taken        = 0;
		error_count        = 0;
		send_idle_pct      = 15;
		recv_stall_pct     = 49;
		parse_word(OP_START, 8'h00);
		cur_phase          = PH_IDLE;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_ignored_words();
		test_basic_report();
		test_saturation_and_errors();
		test_random_reports(15, 49, 120);
		test_random_reports(49, 15, 120);
		test_random_reports(0, 0, 120);

		cmd_bus.valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/sdrp_pkg.sv
rtl/sdrp_if.sv
rtl/socket_data_report_parser.sv
tb/socket_data_report_parser_tb.sv
